// ===== rtl/core/json_string_escape_repair_assert.svh =====
// Assertion macros for the checker file of json_string_escape_repair.
// No dependencies; expects i_clk (and i_rst_n for JSER_ASSERT) in the scope of each use.
`ifndef JSON_STRING_ESCAPE_REPAIR_ASSERT_SVH
`define JSON_STRING_ESCAPE_REPAIR_ASSERT_SVH

// Clocked property, switched off while reset is held.
`define JSER_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that is checked through reset as well.
`define JSER_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/jser_pkg.sv =====
// Package for json_string_escape_repair: character codes, escape phase type,
// command entry layout and sizes. No dependencies.
package jser_pkg;

    // Most output bytes one input byte can produce.
    localparam int MAX_OUT = 12;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    // One segment: a flush or the handling of one byte.
    localparam int SEG_MAX = 6;
    localparam int SEG_W   = $clog2(SEG_MAX + 1);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CTRL_MAX  = 8'h1f;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    localparam logic [7:0] CC_BACKSPACE = 8'h08;
    localparam logic [7:0] CC_TAB       = 8'h09;
    localparam logic [7:0] CC_NEWLINE   = 8'h0a;
    localparam logic [7:0] CC_FORMFEED  = 8'h0c;
    localparam logic [7:0] CC_RETURN    = 8'h0d;

    // Pending escape: backslash seen, or backslash-u with 0..3 digits held.
    typedef enum logic [2:0] {
        PH_NONE = 3'd0,
        PH_BS   = 3'd1,
        PH_U0   = 3'd2,
        PH_U1   = 3'd3,
        PH_U2   = 3'd4,
        PH_U3   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [SEG_MAX-1:0][7:0] b;
        logic [SEG_W-1:0]        len;
    } t_seg;

    // One queue entry: the output bytes of one input item.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } t_cmd;

endpackage

// ===== rtl/core/jser_front.sv =====
// Front end of json_string_escape_repair: string/escape tracking and
// expansion of each input item into a command entry. Depends on jser_pkg.
module jser_front
    import jser_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid
);

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [3:0] v;
        v = n & NIBBLE_MASK;
        if (v < 4'd10) return 8'(CH_0 + {4'h0, v});
        return 8'(CH_LA + {4'h0, v} - 8'd10);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LF) ||
               (b >= CH_UA && b <= CH_UF);
    endfunction

    function automatic logic is_valid_esc(input logic [7:0] b);
        return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
               b == CH_F || b == CH_N || b == CH_R || b == CH_T;
    endfunction

    // Pending sequence emitted as doubled backslash, then u and digits.
    function automatic t_seg flush_seg(input t_phase p, input logic [2:0][7:0] h);
        t_seg s;
        s = '0;
        s.b[0] = CH_BSLASH;
        s.b[1] = CH_BSLASH;
        s.b[2] = CH_U;
        s.b[3] = h[0];
        s.b[4] = h[1];
        s.b[5] = h[2];
        case (p)
            PH_BS:   s.len = SEG_W'(2);
            PH_U0:   s.len = SEG_W'(3);
            PH_U1:   s.len = SEG_W'(4);
            PH_U2:   s.len = SEG_W'(5);
            PH_U3:   s.len = SEG_W'(6);
            default: s.len = '0;
        endcase
        return s;
    endfunction

    // Ordinary string byte with nothing pending (a backslash emits nothing).
    function automatic t_seg plain_seg(input logic [7:0] b);
        t_seg s;
        s = '0;
        if (b == CH_QUOTE) begin
            s.b[0] = b;
            s.len  = SEG_W'(1);
        end else if (b == CH_BSLASH) begin
            s.len = '0;
        end else if (b <= CTRL_MAX) begin
            s.b[0] = CH_BSLASH;
            s.len  = SEG_W'(2);
            case (b)
                CC_BACKSPACE: s.b[1] = CH_B;
                CC_FORMFEED:  s.b[1] = CH_F;
                CC_NEWLINE:   s.b[1] = CH_N;
                CC_RETURN:    s.b[1] = CH_R;
                CC_TAB:       s.b[1] = CH_T;
                default: begin
                    s.b[1] = CH_U;
                    s.b[2] = CH_0;
                    s.b[3] = CH_0;
                    s.b[4] = hex_char(b[7:4]);
                    s.b[5] = hex_char(b[3:0]);
                    s.len  = SEG_W'(6);
                end
            endcase
        end else begin
            s.b[0] = b;
            s.len  = SEG_W'(1);
        end
        return s;
    endfunction

    logic             r_inside, n_inside;
    t_phase           r_phase,  n_phase;
    logic [2:0][7:0]  r_held,   n_held;

    t_seg             w_pre, w_main, w_post;
    logic             w_plain;
    logic [CNT_W-1:0] w_total;
    logic [MAX_OUT-1:0][7:0] w_bytes;

    always_comb begin
        w_pre    = '0;
        w_main   = '0;
        w_post   = '0;
        w_plain  = 1'b0;
        n_inside = r_inside;
        n_phase  = r_phase;
        n_held   = r_held;

        if (!r_inside) begin
            w_main.b[0] = i_in_byte;
            w_main.len  = SEG_W'(1);
            n_inside    = (i_in_byte == CH_QUOTE);
        end else begin
            case (r_phase)
                PH_BS: begin
                    if (i_in_byte == CH_U) begin
                        n_phase = PH_U0;
                    end else if (is_valid_esc(i_in_byte)) begin
                        w_main.b[0] = CH_BSLASH;
                        w_main.b[1] = i_in_byte;
                        w_main.len  = SEG_W'(2);
                        n_phase     = PH_NONE;
                    end else begin
                        w_pre   = flush_seg(r_phase, r_held);
                        w_plain = 1'b1;
                    end
                end
                PH_U0, PH_U1, PH_U2: begin
                    if (is_hex(i_in_byte)) begin
                        case (r_phase)
                            PH_U0: begin
                                n_held[0] = i_in_byte;
                                n_phase   = PH_U1;
                            end
                            PH_U1: begin
                                n_held[1] = i_in_byte;
                                n_phase   = PH_U2;
                            end
                            default: begin
                                n_held[2] = i_in_byte;
                                n_phase   = PH_U3;
                            end
                        endcase
                    end else begin
                        w_pre   = flush_seg(r_phase, r_held);
                        w_plain = 1'b1;
                    end
                end
                PH_U3: begin
                    if (is_hex(i_in_byte)) begin
                        w_main.b[0] = CH_BSLASH;
                        w_main.b[1] = CH_U;
                        w_main.b[2] = r_held[0];
                        w_main.b[3] = r_held[1];
                        w_main.b[4] = r_held[2];
                        w_main.b[5] = i_in_byte;
                        w_main.len  = SEG_W'(6);
                        n_phase     = PH_NONE;
                    end else begin
                        w_pre   = flush_seg(r_phase, r_held);
                        w_plain = 1'b1;
                    end
                end
                default: w_plain = 1'b1;
            endcase

            if (w_plain) begin
                w_main   = plain_seg(i_in_byte);
                n_phase  = (i_in_byte == CH_BSLASH) ? PH_BS : PH_NONE;
                n_inside = (i_in_byte != CH_QUOTE);
            end
        end

        // End of text: flush what is left and go back to the reset state.
        if (i_in_last) begin
            w_post   = flush_seg(n_phase, n_held);
            n_inside = 1'b0;
            n_phase  = PH_NONE;
            n_held   = '0;
        end
    end

    assign w_total = CNT_W'(w_pre.len) + CNT_W'(w_main.len) + CNT_W'(w_post.len);

    // Pack the three segments back to back into the entry.
    for (genvar g = 0; g < MAX_OUT; g++) begin : g_slot
        logic [CNT_W-1:0] k_pre, k_main, k_post;
        assign k_pre  = CNT_W'(g);
        assign k_main = k_pre - CNT_W'(w_pre.len);
        assign k_post = k_main - CNT_W'(w_main.len);
        assign w_bytes[g] =
            (k_pre < CNT_W'(w_pre.len))                          ? w_pre.b[k_pre[SEG_W-1:0]]   :
            (k_pre < CNT_W'(w_pre.len) + CNT_W'(w_main.len))     ? w_main.b[k_main[SEG_W-1:0]] :
            (k_pre < w_total)                                    ? w_post.b[k_post[SEG_W-1:0]] :
                                                                   8'h00;
    end

    assign o_cmd.bytes = w_bytes;
    assign o_cmd.cnt   = w_total;
    assign o_cmd.last  = i_in_last;
    assign o_cmd_valid = i_accept && (w_total != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_phase  <= PH_NONE;
            r_held   <= '0;
        end else if (i_accept) begin
            r_inside <= n_inside;
            r_phase  <= n_phase;
            r_held   <= n_held;
        end
    end

endmodule

// ===== rtl/core/jser_queue.sv =====
// Command queue between front and back of json_string_escape_repair.
// Holds whole command entries; depends on jser_pkg.
module jser_queue
    import jser_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count,  n_count;
    logic              w_wr, w_rd;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign w_wr = i_wr && !o_full;
    assign w_rd = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/jser_back.sv =====
// Back end of json_string_escape_repair: walks each command entry one byte
// per cycle, unless stalled, into the output register. Depends on jser_pkg.
module jser_back
    import jser_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic [CNT_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             w_load, w_end;

    assign w_load    = i_cmd_valid && (!r_out_valid || i_pop);
    assign w_end     = (r_idx == CNT_W'(i_cmd.cnt - 1'b1));
    assign o_cmd_pop = w_load && w_end;

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx       <= w_end ? '0 : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= i_cmd.bytes[r_idx];
            r_out_last <= i_cmd.last && w_end;
        end
    end

endmodule

// ===== rtl/core/json_string_escape_repair.sv =====
// json_string_escape_repair: streaming repair of string escapes in JSON text.
//
// Input channel: a queue write port. An item (i_in_byte, i_in_last) is taken
// at a rising edge with i_push high and o_full low. i_in_last marks the final
// byte of a text. Output channel: a queue read port. While o_empty is low the
// oldest repaired byte is on o_out_byte/o_out_last; i_pop takes it.
// Each input item yields 0 to 12 output items; o_out_last is set on the
// final output item of a text, and every last input item yields at least one.
// The first output item of an input item passes through the command queue
// and then the output register on its way out when nothing waits.
// Throughput: one input item per cycle while o_full is low; the output side
// delivers one item per cycle while the receiver pops, set by the single
// byte-wide output register of the back end.
// Expansion bursts sit in a QUEUE_DEPTH entry command queue; o_full rises
// when it fills. A stalled receiver only holds the output register and,
// once the queue fills, the input side; no item is lost.
// Reset (i_rst_n low, synchronous): leaves all strings and escapes, empties
// the queue and the output register. No clearing pass is needed.
//
// Depends on jser_pkg, jser_front, jser_queue and jser_back.
module json_string_escape_repair
    import jser_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic w_accept;
    t_cmd w_front_cmd;
    logic w_front_valid;
    t_cmd w_head_cmd;
    logic w_head_valid;
    logic w_head_pop;

    // Front: takes an item whenever the queue has room; items that produce
    // no output (held escape bytes) only update the front state.
    assign w_accept = i_push && !o_full;

    jser_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_cmd       (w_front_cmd),
        .o_cmd_valid (w_front_valid)
    );

    // Command queue decouples expansion bursts from the input stream.
    jser_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_front_valid),
        .i_cmd   (w_front_cmd),
        .o_full  (o_full),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd),
        .i_rd    (w_head_pop)
    );

    // Back: serializes the head entry into the output register.
    jser_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_head_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// ===== rtl/core/jser_checker.sv =====
// Port-level checker for json_string_escape_repair, bound to the top level.
// Depends on json_string_escape_repair_assert.svh.
`include "json_string_escape_repair_assert.svh"

module jser_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_push,
    input logic       o_full,
    input logic [7:0] i_in_byte,
    input logic       i_in_last,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    // Reset leaves both sides idle: nothing to read, room to write.
    `JSER_ASSERT_RST(a_reset_idle, !i_rst_n |=> o_empty && !o_full, "not idle after reset")

    // The queue only fills up after an accepted item.
    `JSER_ASSERT(a_full_after_push, $rose(o_full) |-> $past(i_push && !o_full), "full without push")

    // A waiting item stays put while the receiver stalls.
    `JSER_ASSERT(a_out_hold, !o_empty && !i_pop |=> !o_empty && $stable(o_out_byte) && $stable(o_out_last), "output changed under stall")

endmodule

bind json_string_escape_repair jser_checker u_jser_checker (.*);
